// File: rtl/mlptw_pkg.sv
// ----------------------------------------------------------------------------
// mlptw_pkg
// Shared types and codes of the multi-level page table walker: item
// structs, walk sequencer states, operation and status codes.
// ----------------------------------------------------------------------------
package mlptw_pkg;

  // fixed field widths
  localparam int VA_W = 48;
  localparam int PA_W = 18;
  localparam int STATUS_W = 2;

  // operation codes
  localparam logic FUNC_TRANSLATE = 1'b0;
  localparam logic FUNC_ALLOCATE  = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOT_MAPPED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NO_FRAMES  = 2'd2;

  // input item
  typedef struct packed {
    logic            func;
    logic [VA_W-1:0] virtual_address;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [PA_W-1:0]     physical_address;
    logic [STATUS_W-1:0] status;
  } out_item_t;

  // walk sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ROOT,
    ST_READ,
    ST_CHECK,
    ST_FINISH
  } walk_state_t;

endpackage

// File: rtl/multi_level_page_table_walker.sv
// ----------------------------------------------------------------------------
// multi_level_page_table_walker
// Page table walker over an on-block frame store with a bump frame allocator.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data carry one item: func (translate or allocate)
//   and a 48-bit virtual address. out_valid/out_stall/out_data return one
//   result item per input item: physical address and status.
//   A walk runs one level at a time on the single read port of the table
//   store: ST_READ issues the read of an entry, ST_CHECK checks it (and
//   writes a fresh entry on allocate). A new item is taken only once the
//   last result has gone to the output register; a walk that misses early
//   ends sooner, without the remaining levels. in_stall is high while a walk,
//   including its wait for the output register, is in progress.
//   After reset the store is cleared one entry a cycle, all FRAME_COUNT <<
//   (PAGE_OFFSET_BITS-3) entries (32768 by default), with in_stall high.
//   A finished result sits in the output register; while out_stall is high
//   the next walk still runs and waits at its end for the register to free.
// ----------------------------------------------------------------------------
module multi_level_page_table_walker
  import mlptw_pkg::*;
#(
  parameter int PAGE_OFFSET_BITS = 12,
  parameter int LEVEL_COUNT      = 4,
  parameter int FRAME_COUNT      = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int IDX_W       = PAGE_OFFSET_BITS - 3;
  localparam int FRAME_W     = $clog2(FRAME_COUNT);
  localparam int ADDR_W      = FRAME_W + IDX_W;
  localparam int STORE_DEPTH = FRAME_COUNT << IDX_W;
  localparam int ENTRY_W     = FRAME_W + 1;
  localparam int NFF_W       = $clog2(FRAME_COUNT + 1);
  localparam int WALK_W      = IDX_W * LEVEL_COUNT;
  localparam int VA_EXT_W    = (PAGE_OFFSET_BITS + WALK_W > VA_W) ?
                               PAGE_OFFSET_BITS + WALK_W : VA_W;
  localparam int PA_FULL_W   = (FRAME_W + PAGE_OFFSET_BITS > PA_W) ?
                               FRAME_W + PAGE_OFFSET_BITS : PA_W;
  localparam int LVL_W       = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;

  walk_state_t                 state_r, state_nxt;
  logic [ADDR_W-1:0]           clr_cnt_r, clr_cnt_nxt;
  logic                        root_valid_r, root_valid_nxt;
  logic [FRAME_W-1:0]          root_frame_r, root_frame_nxt;
  logic [NFF_W-1:0]            nff_r, nff_nxt;
  logic                        alloc_r, alloc_nxt;
  logic [PAGE_OFFSET_BITS-1:0] off_r, off_nxt;
  logic [WALK_W-1:0]           fields_r, fields_nxt;
  logic [LVL_W-1:0]            lvl_r, lvl_nxt;
  logic [FRAME_W-1:0]          cur_r, cur_nxt;
  logic [PA_W-1:0]             pa_r, pa_nxt;
  logic [STATUS_W-1:0]         status_r, status_nxt;
  logic                        out_valid_r, out_valid_nxt;
  out_item_t                   out_data_r, out_data_nxt;

  logic                        wr_en;
  logic [ADDR_W-1:0]           wr_addr;
  logic [ENTRY_W-1:0]          wr_data;
  logic                        rd_en;
  logic [ADDR_W-1:0]           walk_addr;
  logic [ENTRY_W-1:0]          rd_data;
  logic                        frames_left;
  logic [FRAME_W-1:0]          fresh_frame;
  logic [VA_EXT_W-1:0]         va_ext;

  // table store
  mlptw_store #(
    .DEPTH  (STORE_DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (ENTRY_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (walk_addr),
    .rd_data (rd_data)
  );

  // index fields above the page offset, bits past the address read as zero
  assign va_ext      = VA_EXT_W'(in_data.virtual_address);
  assign walk_addr   = {cur_r, fields_r[WALK_W-1 -: IDX_W]};
  assign frames_left = (nff_r != NFF_W'(FRAME_COUNT));
  assign fresh_frame = nff_r[FRAME_W-1:0];
  assign rd_en       = (state_r == ST_READ);
  assign in_stall    = (state_r != ST_IDLE);
  assign out_valid   = out_valid_r;
  assign out_data    = out_data_r;

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_cnt_r    <= '0;
      root_valid_r <= 1'b0;
      root_frame_r <= '0;
      nff_r        <= '0;
      lvl_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      root_valid_r <= root_valid_nxt;
      root_frame_r <= root_frame_nxt;
      nff_r        <= nff_nxt;
      lvl_r        <= lvl_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // walk payload registers
  always_ff @(posedge clk) begin
    alloc_r    <= alloc_nxt;
    off_r      <= off_nxt;
    fields_r   <= fields_nxt;
    cur_r      <= cur_nxt;
    pa_r       <= pa_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
  end

  // walk sequencer
  always_comb begin
    logic [PA_FULL_W-1:0] pa_full;
    logic                 step_ok;

    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    root_valid_nxt = root_valid_r;
    root_frame_nxt = root_frame_r;
    nff_nxt        = nff_r;
    alloc_nxt      = alloc_r;
    off_nxt        = off_r;
    fields_nxt     = fields_r;
    lvl_nxt        = lvl_r;
    cur_nxt        = cur_r;
    pa_nxt         = pa_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;
    wr_en          = 1'b0;
    wr_addr        = walk_addr;
    wr_data        = '0;
    step_ok        = 1'b0;
    pa_full        = '0;

    unique case (state_r)
      // zero the store one entry a cycle
      ST_CLEAR: begin
        wr_en       = 1'b1;
        wr_addr     = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + ADDR_W'(1);
        if (clr_cnt_r == ADDR_W'(STORE_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      // take an item
      ST_IDLE: begin
        if (in_valid) begin
          alloc_nxt  = (in_data.func == FUNC_ALLOCATE);
          off_nxt    = in_data.virtual_address[PAGE_OFFSET_BITS-1:0];
          fields_nxt = va_ext[PAGE_OFFSET_BITS +: WALK_W];
          lvl_nxt    = '0;
          state_nxt  = ST_ROOT;
        end
      end

      // find or allocate the root table
      ST_ROOT: begin
        if (root_valid_r) begin
          cur_nxt   = root_frame_r;
          state_nxt = ST_READ;
        end else if (!alloc_r) begin
          status_nxt = STATUS_NOT_MAPPED;
          pa_nxt     = '0;
          state_nxt  = ST_FINISH;
        end else if (!frames_left) begin
          status_nxt = STATUS_NO_FRAMES;
          pa_nxt     = '0;
          state_nxt  = ST_FINISH;
        end else begin
          root_valid_nxt = 1'b1;
          root_frame_nxt = fresh_frame;
          cur_nxt        = fresh_frame;
          nff_nxt        = nff_r + NFF_W'(1);
          state_nxt      = ST_READ;
        end
      end

      // entry read issued on the store port
      ST_READ: begin
        state_nxt = ST_CHECK;
      end

      // follow a valid entry or fill a missing one
      ST_CHECK: begin
        if (rd_data[0]) begin
          cur_nxt = rd_data[ENTRY_W-1:1];
          step_ok = 1'b1;
        end else if (!alloc_r) begin
          status_nxt = STATUS_NOT_MAPPED;
          pa_nxt     = '0;
          state_nxt  = ST_FINISH;
        end else if (!frames_left) begin
          status_nxt = STATUS_NO_FRAMES;
          pa_nxt     = '0;
          state_nxt  = ST_FINISH;
        end else begin
          wr_en   = 1'b1;
          wr_data = {fresh_frame, 1'b1};
          cur_nxt = fresh_frame;
          nff_nxt = nff_r + NFF_W'(1);
          step_ok = 1'b1;
        end
        if (step_ok) begin
          if (lvl_r == LVL_W'(LEVEL_COUNT - 1)) begin
            pa_full    = PA_FULL_W'({cur_nxt, off_r});
            pa_nxt     = pa_full[PA_W-1:0];
            status_nxt = STATUS_OK;
            state_nxt  = ST_FINISH;
          end else begin
            lvl_nxt    = lvl_r + LVL_W'(1);
            fields_nxt = fields_r << IDX_W;
            state_nxt  = ST_READ;
          end
        end
      end

      // hand the result to the output register once it is free
      ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt                 = 1'b1;
          out_data_nxt.physical_address = pa_r;
          out_data_nxt.status           = status_r;
          state_nxt                     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // a root once set stays set
  assert property (@(posedge clk) disable iff (!rst_n)
    root_valid_r |=> root_valid_r)
    else $error("root table lost");

  // a root implies a frame was taken from the allocator
  assert property (@(posedge clk) disable iff (!rst_n)
    root_valid_r |-> (nff_r != '0))
    else $error("root set without a frame taken");

  // every store read is followed by its check
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |=> (state_r == ST_CHECK))
    else $error("store read not checked");

  // the allocator never passes the frame count
  assert property (@(posedge clk) disable iff (!rst_n)
    (nff_r == NFF_W'(FRAME_COUNT)) |=> (nff_r == NFF_W'(FRAME_COUNT)))
    else $error("allocator moved after running out");

endmodule

// File: rtl/mlptw_store.sv
// ----------------------------------------------------------------------------
// mlptw_store
// Table store: single write port, single read port with registered data.
// ----------------------------------------------------------------------------
module mlptw_store #(
  parameter int DEPTH  = 32768,
  parameter int ADDR_W = 15,
  parameter int DATA_W = 7
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: verif/multi_level_page_table_walker_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multi_level_page_table_walker_check
// Watches both channels of the walker, keeps its own copy of the page table
// store and frame allocator, works out the result of every accepted item and
// compares each returned result field by field against the oldest one.
// ----------------------------------------------------------------------------
module multi_level_page_table_walker_check
  import mlptw_pkg::*;
#(
  parameter int PAGE_OFFSET_BITS = 12,
  parameter int LEVEL_COUNT      = 4,
  parameter int FRAME_COUNT      = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  output int        error_count,
  output int        pending_count,
  output int        ok_count,
  output int        unmapped_count,
  output int        no_frame_count
);

  localparam int IDX_W   = PAGE_OFFSET_BITS - 3;
  localparam int ENTRIES = 1 << IDX_W;
  localparam int DEPTH   = FRAME_COUNT * ENTRIES;
  localparam int FRAME_W = $clog2(FRAME_COUNT);

  // entry: frame number above a valid bit
  logic [FRAME_W:0]   pte_mem [DEPTH];
  logic               root_ok;
  logic [FRAME_W-1:0] root_frm;
  logic [FRAME_W:0]   free_frm;

  out_item_t walk_results[$];
  int        errs;
  int        n_ok;
  int        n_unmapped;
  int        n_no_frame;

  // index into the table of one level; fields above bit 63 read as zero
  function automatic int level_idx(logic [VA_W-1:0] va, int lvl);
    int          shift;
    logic [63:0] wide;
    shift = PAGE_OFFSET_BITS + IDX_W * (LEVEL_COUNT - 1 - lvl);
    wide  = 64'(va);
    if (shift >= 64) return 0;
    return int'((wide >> shift) & 64'(ENTRIES - 1));
  endfunction

  // walk the table for one item, allocating frames on an allocate
  function automatic out_item_t walk_predict(in_item_t item);
    out_item_t        res;
    logic [FRAME_W:0] cur;
    int               slot;
    logic             alloc;
    logic [63:0]      pa;
    res   = '0;
    alloc = (item.func == FUNC_ALLOCATE);
    // no root yet
    if (!root_ok) begin
      if (!alloc) begin
        res.status = STATUS_NOT_MAPPED;
        return res;
      end
      if (free_frm >= FRAME_COUNT) begin
        res.status = STATUS_NO_FRAMES;
        return res;
      end
      root_frm = free_frm[FRAME_W-1:0];
      free_frm = free_frm + 1'b1;
      root_ok  = 1'b1;
    end
    cur = {1'b0, root_frm};
    for (int lvl = 0; lvl < LEVEL_COUNT; lvl++) begin
      if (cur >= FRAME_COUNT) begin
        res.status = alloc ? STATUS_NO_FRAMES : STATUS_NOT_MAPPED;
        return res;
      end
      slot = int'(cur) * ENTRIES + level_idx(item.virtual_address, lvl);
      // missing entry: fail a translate, fill it on an allocate
      if (!pte_mem[slot][0]) begin
        if (!alloc) begin
          res.status = STATUS_NOT_MAPPED;
          return res;
        end
        if (free_frm >= FRAME_COUNT) begin
          res.status = STATUS_NO_FRAMES;
          return res;
        end
        pte_mem[slot] = {free_frm[FRAME_W-1:0], 1'b1};
        free_frm      = free_frm + 1'b1;
      end
      cur = {1'b0, pte_mem[slot][FRAME_W:1]};
    end
    pa = (64'(cur) << PAGE_OFFSET_BITS)
       | (64'(item.virtual_address) & ((64'd1 << PAGE_OFFSET_BITS) - 64'd1));
    res.physical_address = pa[PA_W-1:0];
    res.status           = STATUS_OK;
    return res;
  endfunction

  // predict on accepted items, compare on accepted results
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) pte_mem[i] = '0;
      root_ok    = 1'b0;
      root_frm   = '0;
      free_frm   = '0;
      walk_results.delete();
      errs       = 0;
      n_ok       = 0;
      n_unmapped = 0;
      n_no_frame = 0;
    end else begin
      if (in_valid && !in_stall) walk_results.push_back(walk_predict(in_data));
      if (out_valid && !out_stall) begin
        if (walk_results.size() == 0) begin
          errs++;
          $display("%0t: unexpected result, expected none, got pa %h status %0d",
                   $time, out_data.physical_address, out_data.status);
        end else begin
          want = walk_results.pop_front();
          if (out_data.physical_address !== want.physical_address) begin
            errs++;
            $display("%0t: physical_address mismatch, expected %h, got %h",
                     $time, want.physical_address, out_data.physical_address);
          end
          if (out_data.status !== want.status) begin
            errs++;
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, want.status, out_data.status);
          end
          case (want.status)
            STATUS_OK:         n_ok++;
            STATUS_NOT_MAPPED: n_unmapped++;
            default:           n_no_frame++;
          endcase
        end
      end
    end
    error_count    <= errs;
    pending_count  <= walk_results.size();
    ok_count       <= n_ok;
    unmapped_count <= n_unmapped;
    no_frame_count <= n_no_frame;
  end

endmodule

// File: verif/multi_level_page_table_walker_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multi_level_page_table_walker_test
// Drives translate and allocate items into the walker: a directed set over
// empty tables, shared prefixes and address extremes, then random walks that
// mostly reuse mapped prefixes, with random gaps and output stalls.
// ----------------------------------------------------------------------------
module multi_level_page_table_walker_test;
  import mlptw_pkg::*;

  localparam int OFFSET_BITS  = 12;
  localparam int LEVELS       = 4;
  localparam int FRAMES       = 64;
  localparam int IDX_W        = OFFSET_BITS - 3;
  localparam int RANDOM_ITEMS = 1040;
  localparam int POOL_DEPTH   = 64;
  localparam int IDLE_LIMIT   = 131072;
  localparam int DRAIN_CYCLES = 40;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_data   = '0;
  logic      out_stall = 1'b0;
  logic      calm      = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_data;

  int error_count;
  int pending_count;
  int ok_count;
  int unmapped_count;
  int no_frame_count;
  int translate_count = 0;
  int allocate_count  = 0;

  logic [VA_W-1:0] va_pool[$];

  multi_level_page_table_walker #(
    .PAGE_OFFSET_BITS(OFFSET_BITS),
    .LEVEL_COUNT(LEVELS),
    .FRAME_COUNT(FRAMES)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  multi_level_page_table_walker_check #(
    .PAGE_OFFSET_BITS(OFFSET_BITS),
    .LEVEL_COUNT(LEVELS),
    .FRAME_COUNT(FRAMES)
  ) u_check (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .error_count(error_count),
    .pending_count(pending_count),
    .ok_count(ok_count),
    .unmapped_count(unmapped_count),
    .no_frame_count(no_frame_count)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // replace one index field (lvl below LEVELS) or the page offset (lvl == LEVELS)
  function automatic logic [VA_W-1:0] put_field(logic [VA_W-1:0] va, int lvl, int value);
    int              shift;
    int              width;
    logic [VA_W-1:0] mask;
    shift = (lvl == LEVELS) ? 0 : OFFSET_BITS + IDX_W * (LEVELS - 1 - lvl);
    width = (lvl == LEVELS) ? OFFSET_BITS : IDX_W;
    mask  = ((VA_W'(1) << width) - VA_W'(1)) << shift;
    return (va & ~mask) | ((VA_W'(value) << shift) & mask);
  endfunction

  function automatic logic [VA_W-1:0] make_va(int i0, int i1, int i2, int i3, int off);
    logic [VA_W-1:0] va;
    va = put_field('0, 0, i0);
    va = put_field(va, 1, i1);
    va = put_field(va, 2, i2);
    va = put_field(va, 3, i3);
    return put_field(va, LEVELS, off);
  endfunction

  // sender gap: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // present one item and hold it until accepted
  task automatic send_item(logic func, logic [VA_W-1:0] va);
    int gap;
    in_data  <= {func, va};
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (func == FUNC_ALLOCATE) begin
      allocate_count++;
      if (va_pool.size() < POOL_DEPTH) va_pool.push_back(va);
      else va_pool[$urandom_range(0, POOL_DEPTH - 1)] = va;
    end else begin
      translate_count++;
    end
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // result side stalls
  initial begin
    int hold;
    int r;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
      end else if (calm) begin
        out_stall <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          out_stall <= 1'b0;
          hold = $urandom_range(0, 6);
        end else if (r < 95) begin
          out_stall <= 1'b1;
          hold = $urandom_range(0, 3);
        end else begin
          out_stall <= 1'b1;
          hold = $urandom_range(15, 60);
        end
      end
    end
  end

  // watchdog on cycles with no item moving on either channel
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // stimulus and verdict
  initial begin
    int              r;
    logic            func;
    logic [VA_W-1:0] va;
    logic [VA_W-1:0] base;
    logic [63:0]     wide;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty table, extremes, shared and missing levels
    send_item(FUNC_TRANSLATE, '0);
    send_item(FUNC_TRANSLATE, '1);
    send_item(FUNC_ALLOCATE, '0);
    send_item(FUNC_ALLOCATE, '0);
    send_item(FUNC_TRANSLATE, make_va(0, 0, 0, 0, 'hfff));
    send_item(FUNC_ALLOCATE, '1);
    send_item(FUNC_TRANSLATE, '1);
    send_item(FUNC_TRANSLATE, make_va(511, 511, 511, 0, 0));
    send_item(FUNC_TRANSLATE, make_va(1, 0, 0, 0, 0));
    send_item(FUNC_ALLOCATE, make_va(0, 0, 0, 1, 'h123));
    send_item(FUNC_ALLOCATE, make_va(0, 0, 1, 7, 0));
    send_item(FUNC_TRANSLATE, make_va(0, 0, 1, 7, 'habc));
    send_item(FUNC_TRANSLATE, make_va(0, 1, 0, 0, 0));
    send_item(FUNC_TRANSLATE, make_va(0, 0, 0, 2, 0));
    send_item(FUNC_ALLOCATE, make_va(511, 511, 511, 511, 0));

    // random: mostly walks near mapped addresses, some raw noise
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm <= ((n / 130) % 4 == 3);
      r    = $urandom_range(0, 99);
      wide = {$urandom, $urandom};
      if (va_pool.size() == 0 || r < 8) begin
        func = ($urandom_range(0, 1) == 1) ? FUNC_ALLOCATE : FUNC_TRANSLATE;
        va   = wide[VA_W-1:0];
      end else begin
        base = va_pool[$urandom_range(0, va_pool.size() - 1)];
        va   = put_field(base, LEVELS, $urandom_range(0, (1 << OFFSET_BITS) - 1));
        if (r < 55) begin
          func = FUNC_TRANSLATE;
        end else if (r < 70) begin
          func = FUNC_ALLOCATE;
        end else if (r < 88) begin
          func = FUNC_ALLOCATE;
          va   = put_field(va, LEVELS - 1, $urandom_range(0, (1 << IDX_W) - 1));
        end else if (r < 94) begin
          func = FUNC_ALLOCATE;
          va   = put_field(va, LEVELS - 1, $urandom_range(0, (1 << IDX_W) - 1));
          va   = put_field(va, LEVELS - 2, $urandom_range(0, (1 << IDX_W) - 1));
        end else begin
          func = FUNC_TRANSLATE;
          va   = put_field(va, $urandom_range(0, LEVELS - 1),
                           $urandom_range(0, (1 << IDX_W) - 1));
        end
      end
      send_item(func, va);
    end
    in_valid <= 1'b0;

    // drain outstanding results, then a short tail
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d items: %0d translates, %0d allocates",
             translate_count + allocate_count, translate_count, allocate_count);
    $display("results seen: %0d mapped, %0d not mapped, %0d out of frames",
             ok_count, unmapped_count, no_frame_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/mlptw_pkg.sv
rtl/mlptw_store.sv
rtl/multi_level_page_table_walker.sv
verif/multi_level_page_table_walker_check.sv
verif/multi_level_page_table_walker_test.sv
